@@ rtl/srpg_pkg.sv @@
package srpg_pkg;

    // field widths
    localparam int IDX_W     = 6;
    localparam int TAB_DEPTH = 64;
    localparam int POS_W     = 32;
    localparam int FRAC_W    = 24;
    localparam int PER_W     = 32;

    // motion phase
    typedef enum logic [1:0] {
        PH_IDLE   = 2'd0,
        PH_UP     = 2'd1,
        PH_CRUISE = 2'd2,
        PH_DOWN   = 2'd3
    } phase_t;

    // request kinds
    localparam logic [1:0] KIND_TICK  = 2'd0;
    localparam logic [1:0] KIND_START = 2'd1;
    localparam logic [1:0] KIND_STOP  = 2'd2;

    typedef struct packed {
        logic [1:0]       kind;
        logic [POS_W-1:0] distance;
    } req_t;

    typedef struct packed {
        logic [7:0]       reload_value;
        logic             reload_valid;
        logic [1:0]       motion_phase;
        logic             finished;
        logic [POS_W-1:0] step_position;
    } rsp_t;

    // acceleration table, unsigned 8.24 periods; the tail repeats the last entry
    function automatic logic [PER_W-1:0] accel_entry(input logic [IDX_W-1:0] idx);
        logic [PER_W-1:0] v;
        unique case (idx)
            6'd0:    v = 32'h4B000000;
            6'd1:    v = 32'h4137A6F4;
            6'd2:    v = 32'h2D745D17;
            6'd3:    v = 32'h1C50D509;
            6'd4:    v = 32'h17D84530;
            6'd5:    v = 32'h13EF9BE2;
            6'd6:    v = 32'h111EC621;
            6'd7:    v = 32'h0F21BDA2;
            6'd8:    v = 32'h0DABFAC7;
            6'd9:    v = 32'h0C8D85E6;
            6'd10:   v = 32'h0BA9FACA;
            6'd11:   v = 32'h0AF000F7;
            6'd12:   v = 32'h0A5480B9;
            6'd13:   v = 32'h09D011A2;
            6'd14:   v = 32'h095D905F;
            6'd15:   v = 32'h08F94EAD;
            6'd16:   v = 32'h08A096A5;
            6'd17:   v = 32'h08515D0A;
            6'd18:   v = 32'h080A0F2A;
            6'd19:   v = 32'h07C97188;
            6'd20:   v = 32'h078E891B;
            6'd21:   v = 32'h07588B5A;
            6'd22:   v = 32'h0726D2DE;
            6'd23:   v = 32'h06F8D714;
            6'd24:   v = 32'h06CE261C;
            6'd25:   v = 32'h06A66029;
            6'd26:   v = 32'h068133FD;
            6'd27:   v = 32'h065E5C2E;
            6'd28:   v = 32'h063D9D09;
            6'd29:   v = 32'h061EC2E2;
            6'd30:   v = 32'h0601A0C1;
            6'd31:   v = 32'h05E60F4D;
            6'd32:   v = 32'h05CBEBED;
            6'd33:   v = 32'h05B31812;
            6'd34:   v = 32'h059B78A0;
            6'd35:   v = 32'h0584F573;
            6'd36:   v = 32'h056F78F9;
            6'd37:   v = 32'h055AEFD6;
            6'd38:   v = 32'h054748A0;
            6'd39:   v = 32'h0534739F;
            6'd40:   v = 32'h05226297;
            6'd41:   v = 32'h0511089E;
            6'd42:   v = 32'h050059F0;
            6'd43:   v = 32'h04F04BD4;
            6'd44:   v = 32'h04E0D47A;
            6'd45:   v = 32'h04D1EAE5;
            6'd46:   v = 32'h04C386D1;
            6'd47:   v = 32'h04B5A0A5;
            6'd48:   v = 32'h04A83160;
            6'd49:   v = 32'h049B3286;
            6'd50:   v = 32'h048E9E1B;
            default: v = 32'h04826E91;
        endcase
        return v;
    endfunction

    // timer reload: integer part minus one, saturated, zero stays zero
    function automatic logic [7:0] reload_of(input logic [PER_W:0] per);
        logic [8:0] ip;
        ip = per[PER_W:FRAC_W];
        if (ip == 9'd0)
            return 8'd0;
        else if (ip > 9'd256)
            return 8'd255;
        else
            return 8'(ip - 9'd1);
    endfunction

endpackage

@@ rtl/srpg_req_if.sv @@
interface srpg_req_if;
    import srpg_pkg::*;

    logic valid;
    logic ready;
    req_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/srpg_rsp_if.sv @@
interface srpg_rsp_if;
    import srpg_pkg::*;

    logic valid;
    logic ready;
    rsp_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/stepper_ramp_period_generator_unit.sv @@
// stepper ramp period generator
//
// req channel (sink): one request per item, kind 0 step tick, 1 start move,
// 2 stop request; distance is used on start only (0 runs until stopped).
// rsp channel (source): exactly one result per request, carrying the timer
// reload, its valid flag, the phase after the request, the finished flag and
// the step position.
// cfg_wr_en / cfg_wr_data write the cruise period (8.24 timer ticks); write
// it only while no request is in flight.
//
// a request is taken into an input register, evaluated against the motion
// state and written to the result register: rsp.valid rises once the request
// moves from the input register into the result register, and one request is
// taken every cycle while the result register is not held. the motion state
// update (table read, 33-bit add, compares) sets that rate.
// when rsp.ready is low the result register holds; one more request is taken
// into the input register, then req.ready drops until the result leaves.
// reset returns the block to idle, position and end zero, and the cruise
// period to 10.0 ticks; no clearing pass is needed.
module stepper_ramp_period_generator_unit #(
    parameter int MICROSTEP_DIV = 2,
    parameter int RAMP_LEN      = 52
) (
    input  logic                       clk,
    input  logic                       rst_n,
    srpg_req_if.sink                   req,
    srpg_rsp_if.source                 rsp,
    input  logic                       cfg_wr_en,
    input  logic [srpg_pkg::PER_W-1:0] cfg_wr_data
);
    import srpg_pkg::*;

    localparam int               RW       = (MICROSTEP_DIV > 1) ? $clog2(MICROSTEP_DIV) : 1;
    localparam int               TW       = RW + 2;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(RAMP_LEN - 1);
    localparam logic [32:0]      TWO32    = 33'h1_0000_0000;
    localparam int               K32      = int'(TWO32 % MICROSTEP_DIV);

    // pipeline registers
    logic             in_valid_reg;
    req_t             in_data_reg;
    logic             rsp_valid_reg;
    rsp_t             rsp_data_reg;
    rsp_t             rsp_next;
    logic             advance;

    // motion state
    logic [PER_W-1:0]  tgt_reg;
    phase_t            phase_reg,   phase_next;
    logic [IDX_W-1:0]  idx_reg,     idx_next;
    logic [POS_W-1:0]  pos_reg,     pos_next;
    logic [POS_W-1:0]  endp_reg,    endp_next;
    logic [FRAC_W-1:0] frac_reg,    frac_next;
    logic [RW-1:0]     pos_mod_reg, pos_mod_next;

    // datapath
    logic [RW-1:0]     drem;
    logic [RW-1:0]     idx_mod_tab [TAB_DEPTH];
    logic [RW-1:0]     idx_mod;
    logic [POS_W-1:0]  pos_inc;
    logic [RW-1:0]     pos_mod_inc;
    logic [IDX_W-1:0]  idx_back2;
    logic [IDX_W-1:0]  idx_dec;
    logic [PER_W:0]    up_per;
    logic [PER_W:0]    back_per;
    logic [PER_W:0]    tgt_per;
    logic [PER_W:0]    down_per;
    logic [PER_W:0]    per_sel;
    logic              emit;
    logic              lim;
    logic              cruise_to_down;
    logic [POS_W:0]    stop_sum;
    logic [TW-1:0]     smod_t0;
    logic [TW-1:0]     smod_t1;
    logic [TW-1:0]     smod;
    logic [POS_W-1:0]  stop_end;
    logic [POS_W-1:0]  start_end;

    // handshake
    assign advance   = in_valid_reg && (!rsp_valid_reg || rsp.ready);
    assign req.ready = !in_valid_reg || advance;
    assign rsp.valid = rsp_valid_reg;
    assign rsp.data  = rsp_data_reg;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (req.ready)
            in_valid_reg <= req.valid;
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
            in_data_reg <= req.data;
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_valid_reg <= 1'b0;
        else if (advance)
            rsp_valid_reg <= 1'b1;
        else if (rsp.ready)
            rsp_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            rsp_data_reg <= rsp_next;
    end

    // cruise period register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tgt_reg <= 32'h0A000000;
        else if (cfg_wr_en)
            tgt_reg <= cfg_wr_data;
    end

    // motion state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_IDLE;
            idx_reg     <= '0;
            pos_reg     <= '0;
            endp_reg    <= '0;
            frac_reg    <= '0;
            pos_mod_reg <= '0;
        end
        else if (advance)
        begin
            phase_reg   <= phase_next;
            idx_reg     <= idx_next;
            pos_reg     <= pos_next;
            endp_reg    <= endp_next;
            frac_reg    <= frac_next;
            pos_mod_reg <= pos_mod_next;
        end
    end

    // start distance rounded down to a microstep multiple
    srpg_mod_const #(
        .DIVISOR (MICROSTEP_DIV)
    ) u_dist_mod (
        .value     (in_data_reg.distance),
        .remainder (drem)
    );

    assign start_end = in_data_reg.distance - POS_W'(drem);

    // index remainder table
    for (genvar g = 0; g < TAB_DEPTH; g++)
    begin : g_idx_mod
        assign idx_mod_tab[g] = RW'(g % MICROSTEP_DIV);
    end

    assign idx_mod = idx_mod_tab[idx_reg];

    // position remainder follows the position counter, including its wrap
    assign pos_inc     = pos_reg + POS_W'(1);
    assign pos_mod_inc = (pos_reg == '1) ? '0 :
                         (pos_mod_reg == RW'(MICROSTEP_DIV - 1)) ? '0 :
                         pos_mod_reg + RW'(1);

    // stop end: index plus position, up to the last position of its group
    assign stop_sum = 33'(pos_reg) + 33'(idx_reg);
    assign smod_t0  = TW'(pos_mod_reg) + TW'(idx_mod);
    assign smod_t1  = stop_sum[POS_W] ? smod_t0 + TW'(MICROSTEP_DIV - K32) : smod_t0;
    assign smod     = (smod_t1 >= TW'(2 * MICROSTEP_DIV)) ? smod_t1 - TW'(2 * MICROSTEP_DIV) :
                      (smod_t1 >= TW'(MICROSTEP_DIV))     ? smod_t1 - TW'(MICROSTEP_DIV) :
                      smod_t1;
    assign stop_end = stop_sum[POS_W-1:0] - POS_W'(smod) + POS_W'(MICROSTEP_DIV - 1);

    // candidate periods
    assign idx_back2 = (idx_reg >= IDX_W'(2)) ? idx_reg - IDX_W'(2) : '0;
    assign idx_dec   = idx_reg - IDX_W'(1);
    assign up_per    = {1'b0, accel_entry(idx_reg)} + 33'(frac_reg);
    assign back_per  = {1'b0, accel_entry(idx_back2)};
    assign tgt_per   = {1'b0, tgt_reg} + 33'(frac_reg);
    assign down_per  = {1'b0, accel_entry(idx_dec)} + 33'(frac_reg);

    // ramp-up limit and cruise end
    assign lim = (endp_reg != '0) && (POS_W'({idx_reg, 1'b0}) >= endp_reg);
    assign cruise_to_down = (endp_reg != '0) &&
                            ((endp_reg <= POS_W'(idx_reg) + POS_W'(1)) ||
                             (pos_inc >= endp_reg - POS_W'(idx_reg) - POS_W'(1)));

    // next state
    always_comb
    begin
        phase_next   = phase_reg;
        idx_next     = idx_reg;
        pos_next     = pos_reg;
        endp_next    = endp_reg;
        frac_next    = frac_reg;
        pos_mod_next = pos_mod_reg;
        per_sel      = '0;
        emit         = 1'b0;
        unique case (in_data_reg.kind)
            KIND_START:
            begin
                pos_next     = '0;
                idx_next     = '0;
                frac_next    = '0;
                pos_mod_next = '0;
                endp_next    = start_end;
                phase_next   = PH_UP;
            end
            KIND_STOP:
            begin
                if (phase_reg == PH_CRUISE && endp_reg == '0)
                    endp_next = stop_end;
            end
            KIND_TICK:
            begin
                unique case (phase_reg)
                    PH_UP:
                    begin
                        pos_next     = pos_inc;
                        pos_mod_next = pos_mod_inc;
                        emit         = 1'b1;
                        if (lim)
                        begin
                            idx_next   = idx_back2;
                            per_sel    = back_per;
                            frac_next  = back_per[FRAC_W-1:0];
                            phase_next = PH_DOWN;
                        end
                        else if (33'(tgt_reg) > up_per)
                        begin
                            per_sel    = up_per;
                            frac_next  = tgt_reg[FRAC_W-1:0];
                            phase_next = PH_CRUISE;
                        end
                        else
                        begin
                            per_sel   = up_per;
                            frac_next = up_per[FRAC_W-1:0];
                            if (idx_reg < LAST_IDX)
                                idx_next = idx_reg + IDX_W'(1);
                        end
                    end
                    PH_CRUISE:
                    begin
                        pos_next     = pos_inc;
                        pos_mod_next = pos_mod_inc;
                        emit         = 1'b1;
                        per_sel      = tgt_per;
                        frac_next    = tgt_per[FRAC_W-1:0];
                        if (cruise_to_down)
                            phase_next = PH_DOWN;
                    end
                    PH_DOWN:
                    begin
                        pos_next     = pos_inc;
                        pos_mod_next = pos_mod_inc;
                        emit         = 1'b1;
                        if (idx_reg == '0)
                        begin
                            per_sel = tgt_per;
                        end
                        else
                        begin
                            idx_next  = idx_dec;
                            per_sel   = down_per;
                            frac_next = down_per[FRAC_W-1:0];
                        end
                        if (idx_next == '0)
                        begin
                            endp_next  = pos_inc;
                            phase_next = PH_IDLE;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            default:
            begin
            end
        endcase
    end

    // result fields
    always_comb
    begin
        rsp_next.reload_valid  = emit;
        rsp_next.reload_value  = emit ? reload_of(per_sel) : 8'd0;
        rsp_next.motion_phase  = phase_next;
        rsp_next.finished      = (in_data_reg.kind == KIND_TICK) &&
                                 (phase_reg == PH_DOWN) && (idx_next == '0);
        rsp_next.step_position = pos_next;
    end

    // checks
    a_fin_ends_move: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg && rsp_data_reg.finished |->
            rsp_data_reg.reload_valid && (rsp_data_reg.motion_phase == PH_IDLE))
        else $error("finished result without a period or outside idle");

    a_idx_in_table: assert property (@(posedge clk) disable iff (!rst_n)
        idx_reg <= LAST_IDX)
        else $error("ramp index beyond the table end");

    a_pos_mod_range: assert property (@(posedge clk) disable iff (!rst_n)
        32'(pos_mod_reg) < 32'(MICROSTEP_DIV))
        else $error("position remainder out of range");

    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !req.ready |-> in_valid_reg && rsp_valid_reg && !rsp.ready)
        else $error("request refused with room in the pipeline");

endmodule

@@ rtl/srpg_mod_const.sv @@
module srpg_mod_const #(
    parameter int DIVISOR = 2
) (
    input  logic [srpg_pkg::POS_W-1:0]                      value,
    output logic [((DIVISOR > 1) ? $clog2(DIVISOR) : 1)-1:0] remainder
);
    import srpg_pkg::*;

    localparam int  RW     = (DIVISOR > 1) ? $clog2(DIVISOR) : 1;
    localparam bit  IS_POW2 = ((DIVISOR & (DIVISOR - 1)) == 0);

    if (IS_POW2) begin : g_pow2
        // power of two: plain mask
        assign remainder = RW'(value & POS_W'(DIVISOR - 1));
    end
    else begin : g_recip
        localparam int          C1    = 256 % DIVISOR;
        localparam int          C2    = 65536 % DIVISOR;
        localparam int          C3    = 16777216 % DIVISOR;
        localparam int          SHIFT = 22;
        localparam logic [22:0] RECIP = 23'(((1 << SHIFT) + DIVISOR - 1) / DIVISOR);

        logic [15:0] fold;
        logic [38:0] prod;
        logic [15:0] quot;
        logic [15:0] qd;
        logic [15:0] rem16;

        // fold the bytes with their weights mod the divisor, stays below 2^16
        assign fold = 16'(value[7:0])
                    + 16'(value[15:8])  * 16'(C1)
                    + 16'(value[23:16]) * 16'(C2)
                    + 16'(value[31:24]) * 16'(C3);

        // exact quotient by reciprocal for values below 2^16
        assign prod  = 39'(fold) * 39'(RECIP);
        assign quot  = prod[SHIFT+15:SHIFT];
        assign qd    = 16'(quot * 16'(DIVISOR));
        assign rem16 = fold - qd;

        assign remainder = RW'(rem16);
    end

endmodule
